// ===== rtl/core/ps2hfe_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2hfe_pkg
// Shared types and constants for the ps/2 host frame engine: frame positions,
// operation and error codes, and the beat and state records.
// ----------------------------------------------------------------------------
package ps2hfe_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned IN_DATA_W = 16;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [POS_W-1:0] POS_START     = 4'd0;
    localparam logic [POS_W-1:0] TX_PARITY_POS = 4'd8;
    localparam logic [POS_W-1:0] RX_PARITY_POS = 4'd9;
    localparam logic [POS_W-1:0] RX_STOP_POS   = 4'd10;

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_SEND = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_START  = 2'd1,
        ERR_PARITY = 2'd2,
        ERR_STOP   = 2'd3
    } frame_err_t;

    typedef struct packed {
        op_t               operation;
        logic              line_level;
        logic [BYTE_W-1:0] send_byte;
    } item_t;

    typedef struct packed {
        logic              transmit_mode;
        logic [POS_W-1:0]  bit_position;
        logic [BYTE_W-1:0] receive_shift;
        logic [BYTE_W-1:0] transmit_hold;
        logic              line_drive_level;
    } frame_state_t;

    typedef struct packed {
        logic              sending;
        logic              send_done;
        frame_err_t        frame_error;
        logic [BYTE_W-1:0] received_byte;
        logic              byte_valid;
        logic              drive_data_low;
    } result_t;

endpackage

// ===== rtl/core/ps2hfe_step.sv =====
// ----------------------------------------------------------------------------
// ps2hfe_step
// One frame step: from the current frame state and one item, forms the next
// state and the result of the item.
// ----------------------------------------------------------------------------
module ps2hfe_step (
    input  ps2hfe_pkg::frame_state_t st,
    input  ps2hfe_pkg::item_t        item,
    output ps2hfe_pkg::frame_state_t st_next,
    output ps2hfe_pkg::result_t      res
);

    always_comb begin
        st_next = st;
        res     = '0;
        res.frame_error = ps2hfe_pkg::ERR_NONE;

        if (item.operation == ps2hfe_pkg::OP_SEND) begin
            st_next.transmit_hold    = item.send_byte;
            st_next.transmit_mode    = 1'b1;
            st_next.bit_position     = ps2hfe_pkg::POS_START;
            st_next.line_drive_level = 1'b1;
        end else if (st.transmit_mode) begin
            if (st.bit_position < ps2hfe_pkg::TX_PARITY_POS) begin
                st_next.line_drive_level = ~st.transmit_hold[st.bit_position[2:0]];
                st_next.bit_position     = st.bit_position + 4'd1;
            end else if (st.bit_position == ps2hfe_pkg::TX_PARITY_POS) begin
                // odd parity bit is low exactly when the data has odd ones
                st_next.line_drive_level = ^st.transmit_hold;
                st_next.bit_position     = st.bit_position + 4'd1;
            end else begin
                st_next.line_drive_level = 1'b0;
                st_next.transmit_mode    = 1'b0;
                st_next.bit_position     = ps2hfe_pkg::POS_START;
                res.send_done            = 1'b1;
            end
        end else begin
            if (st.bit_position == ps2hfe_pkg::POS_START) begin
                if (item.line_level) begin
                    res.frame_error = ps2hfe_pkg::ERR_START;
                end else begin
                    st_next.bit_position = 4'd1;
                end
            end else if (st.bit_position < ps2hfe_pkg::RX_PARITY_POS) begin
                st_next.receive_shift = {item.line_level, st.receive_shift[7:1]};
                st_next.bit_position  = st.bit_position + 4'd1;
            end else if (st.bit_position == ps2hfe_pkg::RX_PARITY_POS) begin
                if ((^st.receive_shift) == item.line_level) begin
                    res.frame_error      = ps2hfe_pkg::ERR_PARITY;
                    st_next.bit_position = ps2hfe_pkg::POS_START;
                end else begin
                    st_next.bit_position = st.bit_position + 4'd1;
                end
            end else if (st.bit_position == ps2hfe_pkg::RX_STOP_POS) begin
                if (!item.line_level) begin
                    res.frame_error = ps2hfe_pkg::ERR_STOP;
                end else begin
                    res.byte_valid    = 1'b1;
                    res.received_byte = st.receive_shift;
                end
                st_next.bit_position = ps2hfe_pkg::POS_START;
            end else begin
                st_next.bit_position = ps2hfe_pkg::POS_START;
            end
        end

        res.drive_data_low = st_next.line_drive_level;
        res.sending        = st_next.transmit_mode;
    end

endmodule

// ===== rtl/core/ps2_host_frame_engine.sv =====
// ----------------------------------------------------------------------------
// ps2_host_frame_engine
// PS/2 host frame engine: walks receive frames on clock edge beats and drives
// transmit frames after a send request, one result beat per input beat.
//
//   channel | dir | fields
//   s_*     | in  | tuser: operation; tdata: line_level, send_byte
//   m_*     | out | tdata: drive_data_low .. sending
//
// an input beat is registered, then stepped into the result register once the
// result side can take it; sustained rate is one beat per cycle while the result
// is not stalled, as the frame step is combinational.
// reset returns to receive mode at the start position with the line released.
// a stalled result holds both registers; s_tready drops only when both hold.
// ----------------------------------------------------------------------------
module ps2_host_frame_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ps2hfe_pkg::IN_DATA_W-1:0]    s_tdata,  // [0] line_level, [8:1] send_byte
    input  logic                                s_tuser,  // [0] operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ps2hfe_pkg::OUT_DATA_W-1:0]   m_tdata   // [0] drive_data_low,
                                                          // [1] byte_valid,
                                                          // [9:2] received_byte,
                                                          // [11:10] frame_error,
                                                          // [12] send_done, [13] sending
);

    logic                     in_valid_reg;
    ps2hfe_pkg::item_t        in_item_reg;
    ps2hfe_pkg::frame_state_t st_reg;
    ps2hfe_pkg::frame_state_t st_next;
    ps2hfe_pkg::result_t      step_res;
    logic                     out_valid_reg;
    ps2hfe_pkg::result_t      out_res_reg;
    logic                     advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ps2hfe_step u_step (
        .st      (st_reg),
        .item    (in_item_reg),
        .st_next (st_next),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                st_reg        <= st_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.operation  <= ps2hfe_pkg::op_t'(s_tuser);
            in_item_reg.line_level <= s_tdata[0];
            in_item_reg.send_byte  <= s_tdata[8:1];
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ps/2 host frame engine. A queue of host events
// (clock edges with a sampled data level, and send requests) is streamed in
// with random gaps. Every accepted beat is stepped through a local model of
// the frame logic. Result beats are taken with random stalls, with two long
// hold-offs, and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RANDOM_EVENTS = 1700;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned DRAIN_CYCLES  = 10;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [0] line_level, [8:1] send_byte
    logic        s_tuser  = 1'b0; // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] drive_data_low, [1] byte_valid, [9:2] received_byte,
                                  // [11:10] frame_error, [12] send_done, [13] sending

    ps2hfe_pkg::item_t        host_events[$];
    ps2hfe_pkg::result_t      line_results[$];
    ps2hfe_pkg::frame_state_t host_state;

    bit          in_taken, out_taken;
    bit          tx_calm, rx_calm;
    int unsigned send_gap, stall_left, events_sent, results_seen;
    int unsigned mismatches, idle_cycles;

    ps2_host_frame_engine DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned pick_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // one host event through the frame logic
    task automatic step_host_frame(input ps2hfe_pkg::item_t ev,
                                   output ps2hfe_pkg::result_t r);
        r = '0;
        r.frame_error = ps2hfe_pkg::ERR_NONE;
        if (ev.operation == ps2hfe_pkg::OP_SEND) begin
            host_state.transmit_hold    = ev.send_byte;
            host_state.transmit_mode    = 1'b1;
            host_state.bit_position     = ps2hfe_pkg::POS_START;
            host_state.line_drive_level = 1'b1;
        end else if (host_state.transmit_mode) begin
            if (host_state.bit_position < ps2hfe_pkg::TX_PARITY_POS) begin
                host_state.line_drive_level =
                    ~host_state.transmit_hold[host_state.bit_position[2:0]];
                host_state.bit_position = host_state.bit_position + 4'd1;
            end else if (host_state.bit_position == ps2hfe_pkg::TX_PARITY_POS) begin
                host_state.line_drive_level = ^host_state.transmit_hold;
                host_state.bit_position = host_state.bit_position + 4'd1;
            end else begin
                host_state.line_drive_level = 1'b0;
                host_state.transmit_mode    = 1'b0;
                host_state.bit_position     = ps2hfe_pkg::POS_START;
                r.send_done = 1'b1;
            end
        end else begin
            if (host_state.bit_position == ps2hfe_pkg::POS_START) begin
                if (ev.line_level)
                    r.frame_error = ps2hfe_pkg::ERR_START;
                else
                    host_state.bit_position = ps2hfe_pkg::POS_START + 4'd1;
            end else if (host_state.bit_position < ps2hfe_pkg::RX_PARITY_POS) begin
                host_state.receive_shift = {ev.line_level, host_state.receive_shift[7:1]};
                host_state.bit_position = host_state.bit_position + 4'd1;
            end else if (host_state.bit_position == ps2hfe_pkg::RX_PARITY_POS) begin
                if ((^host_state.receive_shift) == ev.line_level) begin
                    r.frame_error = ps2hfe_pkg::ERR_PARITY;
                    host_state.bit_position = ps2hfe_pkg::POS_START;
                end else begin
                    host_state.bit_position = host_state.bit_position + 4'd1;
                end
            end else if (host_state.bit_position == ps2hfe_pkg::RX_STOP_POS) begin
                if (!ev.line_level) begin
                    r.frame_error = ps2hfe_pkg::ERR_STOP;
                end else begin
                    r.byte_valid    = 1'b1;
                    r.received_byte = host_state.receive_shift;
                end
                host_state.bit_position = ps2hfe_pkg::POS_START;
            end else begin
                host_state.bit_position = ps2hfe_pkg::POS_START;
            end
        end
        r.drive_data_low = host_state.line_drive_level;
        r.sending        = host_state.transmit_mode;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_event(ps2hfe_pkg::op_t op, bit d, logic [7:0] b);
        ps2hfe_pkg::item_t ev;
        ev.operation  = op;
        ev.line_level = d;
        ev.send_byte  = b;
        host_events.push_back(ev);
    endtask

    task automatic add_edge(bit d);
        add_event(ps2hfe_pkg::OP_EDGE, d, 8'($urandom));
    endtask

    task automatic add_rx_frame(logic [7:0] b, bit bad_parity, bit bad_stop);
        add_edge(1'b0);
        for (int i = 0; i < 8; i++)
            add_edge(b[i]);
        add_edge((~^b) ^ bad_parity);
        add_edge(~bad_stop);
    endtask

    // send request followed by a number of clock edges
    task automatic add_tx_frame(logic [7:0] b, int unsigned edges);
        add_event(ps2hfe_pkg::OP_SEND, 1'($urandom), b);
        for (int unsigned i = 0; i < edges; i++)
            add_edge(1'($urandom));
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // beat monitor and checker
    always @(posedge aclk) begin : monitor
        ps2hfe_pkg::item_t   seen;
        ps2hfe_pkg::result_t want, got;
        if (aresetn) begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                seen.operation  = ps2hfe_pkg::op_t'(s_tuser);
                seen.line_level = s_tdata[0];
                seen.send_byte  = s_tdata[8:1];
                step_host_frame(seen, want);
                line_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (line_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %0h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = line_results.pop_front();
                    got  = m_tdata[13:0];
                    check_field("drive_data_low", want.drive_data_low, got.drive_data_low);
                    check_field("byte_valid", want.byte_valid, got.byte_valid);
                    check_field("received_byte", want.received_byte, got.received_byte);
                    check_field("frame_error", want.frame_error, got.frame_error);
                    check_field("send_done", want.send_done, got.send_done);
                    check_field("sending", want.sending, got.sending);
                    check_field("tdata pad", 0, m_tdata[15:14]);
                end
            end
        end
    end

    // input driver
    always @(negedge aclk) begin : driver
        ps2hfe_pkg::item_t nxt;
        if (aresetn) begin
            if (!s_tvalid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (host_events.size() > 0) begin
                    nxt = host_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.operation;
                    s_tdata  <= {7'd0, nxt.send_byte, nxt.line_level};
                    events_sent++;
                    if (events_sent % 100 == 0)
                        tx_calm = ($urandom_range(0, 2) == 0);
                    send_gap = pick_wait(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(negedge aclk) begin : receiver
        if (aresetn) begin
            if (out_taken) begin
                results_seen++;
                if (results_seen % 128 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                if (results_seen == 400 || results_seen == 1100)
                    stall_left = LONG_HOLD;
                else
                    stall_left = pick_wait(rx_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // no beat moving on either side for too long
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int unsigned directed;
        host_state = '0;

        // bad start out of reset, clean frame, send cut short, full send
        add_edge(1'b1);
        add_rx_frame(8'hFF, 1'b0, 1'b0);
        add_tx_frame(8'hA5, 3);
        add_tx_frame(8'h00, 10);
        directed = host_events.size();

        while (host_events.size() < directed + RANDOM_EVENTS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_rx_frame(pick_byte(), 1'b0, 1'b0);
                4:          add_rx_frame(pick_byte(), 1'b1, 1'b0);
                5:          add_rx_frame(pick_byte(), 1'b0, 1'b1);
                6: begin
                    add_tx_frame(pick_byte(), 10);
                    repeat ($urandom_range(0, 2))
                        add_edge(1'b1);
                end
                7: begin
                    add_tx_frame(pick_byte(), $urandom_range(0, 9));
                    add_tx_frame(pick_byte(), 10);
                end
                8: begin
                    add_edge(1'b0);
                    repeat ($urandom_range(1, 9))
                        add_edge(1'($urandom));
                    add_tx_frame(pick_byte(), 10);
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        add_edge(1'($urandom));
                    add_tx_frame(pick_byte(), 10);
                end
            endcase
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        while (host_events.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (line_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
